// ===== design/cmsi_pkg.sv =====
// ----------------------------------------------------------------------------
// cmsi_pkg
// Shared types and constants for the scanline interrupt bank mapper.
// ----------------------------------------------------------------------------
package cmsi_pkg;

  // payload widths
  localparam int KindW   = 3;
  localparam int AddrW   = 16;
  localparam int ByteW   = 8;
  localparam int OffsetW = 21;
  localparam int DelayW  = 5;

  // configuration port
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  // register indexes (word addresses on the config port)
  localparam logic [1:0] REG_PRG_MASK  = 2'd0;
  localparam logic [1:0] REG_CHR_MASK  = 2'd1;
  localparam logic [1:0] REG_IRQ_DELAY = 2'd2;

  // register reset values
  localparam logic [ByteW-1:0]  PRG_MASK_RST  = 8'hFF;
  localparam logic [ByteW-1:0]  CHR_MASK_RST  = 8'hFF;
  localparam logic [DelayW-1:0] IRQ_DELAY_RST = 5'd7;

  // item kinds
  localparam logic [KindW-1:0] KIND_WRITE    = 3'd0;
  localparam logic [KindW-1:0] KIND_SCANLINE = 3'd1;
  localparam logic [KindW-1:0] KIND_CYCLES   = 3'd2;
  localparam logic [KindW-1:0] KIND_PRG      = 3'd3;
  localparam logic [KindW-1:0] KIND_CHR      = 3'd4;

  // fixed program banks for the top 16 KB
  localparam logic [ByteW-1:0] PRG_FIXED_LO = 8'hFE;
  localparam logic [ByteW-1:0] PRG_FIXED_HI = 8'hFF;

  typedef logic [KindW-1:0]   kind_t;
  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [OffsetW-1:0] offset_t;
  typedef logic [DelayW-1:0]  delay_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    byte_t  prg_mask;
    byte_t  chr_mask;
    delay_t irq_delay;
  } cfg_t;

endpackage

// ===== design/cmsi_if.sv =====
// ----------------------------------------------------------------------------
// cmsi_item_if / cmsi_result_if
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
interface cmsi_item_if;
  import cmsi_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  addr_t address;
  byte_t value;
  byte_t cycles;

  modport source (output valid, kind, address, value, cycles, input ready);
  modport sink   (input valid, kind, address, value, cycles, output ready);
endinterface

interface cmsi_result_if;
  import cmsi_pkg::*;

  logic    valid;
  logic    ready;
  offset_t rom_offset;
  logic    irq_line;
  logic    mirror_vertical;

  modport source (output valid, rom_offset, irq_line, mirror_vertical, input ready);
  modport sink   (input valid, rom_offset, irq_line, mirror_vertical, output ready);
endinterface

// ===== design/cmsi_regs.sv =====
// ----------------------------------------------------------------------------
// cmsi_regs
// APB-style configuration registers: program mask, character mask, irq delay.
// ----------------------------------------------------------------------------
module cmsi_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmsi_pkg::PaddrW-1:0]   paddr,
  input  logic [cmsi_pkg::PdataW-1:0]   pwdata,
  output logic [cmsi_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output cmsi_pkg::cfg_t                cfg
);
  import cmsi_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PaddrW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_mask  <= PRG_MASK_RST;
      cfg.chr_mask  <= CHR_MASK_RST;
      cfg.irq_delay <= IRQ_DELAY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PRG_MASK:  cfg.prg_mask  <= pwdata[ByteW-1:0];
        REG_CHR_MASK:  cfg.chr_mask  <= pwdata[ByteW-1:0];
        REG_IRQ_DELAY: cfg.irq_delay <= pwdata[DelayW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PRG_MASK:  prdata = {{(PdataW-ByteW){1'b0}}, cfg.prg_mask};
      REG_CHR_MASK:  prdata = {{(PdataW-ByteW){1'b0}}, cfg.chr_mask};
      REG_IRQ_DELAY: prdata = {{(PdataW-DelayW){1'b0}}, cfg.irq_delay};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== design/cmsi_core.sv =====
// ----------------------------------------------------------------------------
// cmsi_core
// Input register, mapper state with one-pass update, and result register.
// ----------------------------------------------------------------------------
module cmsi_core (
  input  logic             clk,
  input  logic             rst,
  input  cmsi_pkg::cfg_t   cfg,
  cmsi_item_if.sink        item,
  cmsi_result_if.source    result
);
  import cmsi_pkg::*;

  // input register
  logic  s1_valid;
  kind_t s1_kind;
  addr_t s1_address;
  byte_t s1_value;
  byte_t s1_cycles;
  logic  advance;

  // mapper state
  byte_t  prog_banks [2];
  byte_t  char_banks [6];
  logic   mirror_bit;
  byte_t  line_counter;
  byte_t  reload_latch;
  logic   irq_enabled;
  logic   reload_pending;
  delay_t delay_left;
  logic   irq_asserted;

  byte_t   prog_banks_next [2];
  byte_t   char_banks_next [6];
  logic    mirror_bit_next;
  byte_t   line_counter_next;
  byte_t   reload_latch_next;
  logic    irq_enabled_next;
  logic    reload_pending_next;
  delay_t  delay_left_next;
  logic    irq_asserted_next;
  offset_t offset_next;

  // lookup helpers
  byte_t      prg_bank;
  byte_t      chr_bank;
  logic [2:0] chr_slot;
  byte_t      chr_src;

  assign advance    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      s1_kind    <= item.kind;
      s1_address <= item.address;
      s1_value   <= item.value;
      s1_cycles  <= item.cycles;
    end
  end

  // program lookup bank select
  always_comb begin
    case (s1_address[14:13])
      2'd0:    prg_bank = prog_banks[0];
      2'd1:    prg_bank = prog_banks[1];
      2'd2:    prg_bank = PRG_FIXED_LO;
      default: prg_bank = PRG_FIXED_HI;
    endcase
    prg_bank = prg_bank & cfg.prg_mask;
  end

  // character lookup bank select: 2 KB slots double the bank number
  always_comb begin
    chr_slot = s1_address[12:10];
    if (!chr_slot[2]) begin
      chr_src  = char_banks[{2'b00, chr_slot[1]}];
      chr_bank = {chr_src[ByteW-2:0], chr_slot[0]};
    end else begin
      chr_src  = char_banks[3'd2 + {1'b0, chr_slot[1:0]}];
      chr_bank = chr_src;
    end
    chr_bank = chr_bank & cfg.chr_mask;
  end

  // state update and result for the item in the input register
  always_comb begin
    prog_banks_next     = prog_banks;
    char_banks_next     = char_banks;
    mirror_bit_next     = mirror_bit;
    line_counter_next   = line_counter;
    reload_latch_next   = reload_latch;
    irq_enabled_next    = irq_enabled;
    reload_pending_next = reload_pending;
    delay_left_next     = delay_left;
    irq_asserted_next   = irq_asserted;
    offset_next         = '0;

    case (s1_kind)
      KIND_WRITE: begin
        case (s1_address[15:13])
          3'b100: begin
            if (!s1_address[1]) prog_banks_next[s1_address[0]] = s1_value;
            else                char_banks_next[{2'b00, s1_address[0]}] = s1_value;
          end
          3'b101: char_banks_next[3'd2 + {1'b0, s1_address[1:0]}] = s1_value;
          3'b110: begin
            case (s1_address[1:0])
              2'd0: begin
                irq_asserted_next = 1'b0;
                reload_latch_next = ~s1_value;
              end
              2'd1: begin
                irq_asserted_next   = 1'b0;
                line_counter_next   = '0;
                reload_pending_next = 1'b1;
              end
              2'd2: irq_enabled_next = 1'b1;
              default: begin
                irq_asserted_next = 1'b0;
                irq_enabled_next  = 1'b0;
              end
            endcase
          end
          3'b111:  mirror_bit_next = s1_value[6];
          default: ; // below the mapper's register space
        endcase
      end
      KIND_SCANLINE: begin
        if (line_counter == '0 || reload_pending) line_counter_next = reload_latch;
        else                                      line_counter_next = line_counter - 8'd1;
        if (line_counter_next == '0 && irq_enabled) delay_left_next = cfg.irq_delay;
        reload_pending_next = 1'b0;
      end
      KIND_CYCLES: begin
        if (delay_left != '0 && s1_cycles != '0) begin
          if (s1_cycles >= {{(ByteW-DelayW){1'b0}}, delay_left}) begin
            delay_left_next   = '0;
            irq_asserted_next = 1'b1;
          end else begin
            delay_left_next = delay_left - s1_cycles[DelayW-1:0];
          end
        end
      end
      KIND_PRG: begin
        if (s1_address[15]) offset_next = {prg_bank, s1_address[12:0]};
      end
      KIND_CHR: begin
        if (s1_address[15:13] == 3'b000)
          offset_next = {{(OffsetW-ByteW-10){1'b0}}, chr_bank, s1_address[9:0]};
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_banks[0]  <= 8'd0;
      prog_banks[1]  <= 8'd1;
      char_banks[0]  <= 8'd0;
      char_banks[1]  <= 8'd1;
      char_banks[2]  <= 8'd4;
      char_banks[3]  <= 8'd5;
      char_banks[4]  <= 8'd6;
      char_banks[5]  <= 8'd7;
      mirror_bit     <= 1'b0;
      line_counter   <= '0;
      reload_latch   <= '0;
      irq_enabled    <= 1'b0;
      reload_pending <= 1'b0;
      delay_left     <= '0;
      irq_asserted   <= 1'b0;
    end else if (advance) begin
      prog_banks     <= prog_banks_next;
      char_banks     <= char_banks_next;
      mirror_bit     <= mirror_bit_next;
      line_counter   <= line_counter_next;
      reload_latch   <= reload_latch_next;
      irq_enabled    <= irq_enabled_next;
      reload_pending <= reload_pending_next;
      delay_left     <= delay_left_next;
      irq_asserted   <= irq_asserted_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (advance) begin
      result.rom_offset      <= offset_next;
      result.irq_line        <= irq_asserted_next;
      result.mirror_vertical <= ~mirror_bit_next;
    end
  end

endmodule

// ===== design/cartridge_mapper_scanline_irq.sv =====
// ----------------------------------------------------------------------------
// cartridge_mapper_scanline_irq
// Cartridge bank mapper with scanline counter and delayed interrupt line.
// ----------------------------------------------------------------------------
// Usage: each word on the item channel is a CPU register write, a scanline
// tick, an elapsed CPU time report, or a program/character address
// lookup. Every item yields exactly one word on the result channel: the
// mapped ROM offset (zero for non-lookups), the interrupt line and the
// mirroring, all as they stand after that item.
// An accepted item is loaded into the input register; the state update then
// runs it into the result register once the result register is free.
// Throughput is one item per cycle while the result receiver does not stall;
// the state update is a single combinational pass between those two registers.
// The APB port holds the program mask, character mask and interrupt delay;
// write them only while no item is in flight. pready is tied high.
// Reset (rst, synchronous) restores the power-on banks, clears the counter
// and interrupt, and empties both registers. When the result receiver
// stalls, the result word holds; if the input register is empty, one more
// item is still taken into it before item.ready drops.
// ----------------------------------------------------------------------------
module cartridge_mapper_scanline_irq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmsi_pkg::PaddrW-1:0]   paddr,
  input  logic [cmsi_pkg::PdataW-1:0]   pwdata,
  output logic [cmsi_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  cmsi_item_if.sink                     item,
  cmsi_result_if.source                 result
);
  import cmsi_pkg::*;

  cfg_t cfg;

  // configuration registers
  cmsi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // mapper datapath
  cmsi_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

endmodule

// ===== design/cmsi_checker.sv =====
// ----------------------------------------------------------------------------
// cmsi_checker
// Port-level checks for the mapper, bound to the top level.
// ----------------------------------------------------------------------------
module cmsi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic [cmsi_pkg::PaddrW-1:0]   paddr,
  input logic [cmsi_pkg::PdataW-1:0]   prdata,
  input logic                          pready,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [cmsi_pkg::OffsetW-1:0]  result_rom_offset
);
  import cmsi_pkg::*;

  // config port never waits
  a_pready_high: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_rom_offset))
    else $error("stalled result changed");

  // delay register reads back within its five bits
  a_delay_width: assert property (@(posedge clk) disable iff (rst)
    psel && paddr[PaddrW-1:2] == REG_IRQ_DELAY |-> prdata[PdataW-1:DelayW] == '0)
    else $error("irq delay readback too wide");

  // items are taken while the result side is free
  a_accept_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid && !$past(item_valid && item_ready) |-> item_ready)
    else $error("item stalled with empty pipeline");

endmodule

bind cartridge_mapper_scanline_irq cmsi_checker u_cmsi_checker (
  .clk               (clk),
  .rst               (rst),
  .psel              (psel),
  .paddr             (paddr),
  .prdata            (prdata),
  .pready            (pready),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_rom_offset (result.rom_offset)
);
